>>> rtl/core/itrt_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// itrt_pkg: shared types and constants for the radix text converter
// Word formats, the job passed from the front end to the digit engine and the
// digit to ASCII mapping.
// ----------------------------------------------------------------------------
package itrt_pkg;

    localparam int VALUE_BITS = 32;
    localparam int RADIX_BITS = 6;
    localparam int CHAR_BITS  = 7;
    // A remainder is always below the base, which is at most 36.
    localparam int REM_BITS   = 6;
    localparam int IDX_BITS   = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;

    localparam int FIFO_DEPTH    = 2;
    localparam int FIFO_PTR_BITS = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int FIFO_CNT_BITS = $clog2(FIFO_DEPTH + 1);

    localparam logic [RADIX_BITS-1:0] RADIX_MIN     = RADIX_BITS'(2);
    localparam logic [RADIX_BITS-1:0] RADIX_MAX     = RADIX_BITS'(36);
    localparam logic [RADIX_BITS-1:0] RADIX_DECIMAL = RADIX_BITS'(10);

    localparam logic [CHAR_BITS-1:0] CHAR_ZERO   = 7'h30;
    localparam logic [CHAR_BITS-1:0] CHAR_LETTER = 7'h61;
    localparam logic [CHAR_BITS-1:0] CHAR_MINUS  = 7'h2d;
    localparam logic [CHAR_BITS-1:0] CHAR_TEN    = 7'd10;
    localparam logic [REM_BITS-1:0]  DIGIT_NINE  = REM_BITS'(9);

    typedef struct packed {
        logic signed [VALUE_BITS-1:0] value;
        logic [RADIX_BITS-1:0]        radix;
    } in_word_t;

    typedef struct packed {
        logic [CHAR_BITS-1:0] character;
        logic                 last;
    } out_word_t;

    typedef struct packed {
        logic [VALUE_BITS-1:0] mag;
        logic [RADIX_BITS-1:0] base;
        logic                  neg;
    } job_t;

    function automatic logic [CHAR_BITS-1:0] digit_char(input logic [REM_BITS-1:0] d);
        logic [CHAR_BITS-1:0] dx;
        dx = {{(CHAR_BITS-REM_BITS){1'b0}}, d};
        if (d > DIGIT_NINE) begin
            return CHAR_LETTER + dx - CHAR_TEN;
        end
        return CHAR_ZERO + dx;
    endfunction

endpackage
`default_nettype wire

>>> rtl/core/itrt_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// itrt_front: input classifier
// Clamps the base into range, decides whether a minus sign is due and forms
// the magnitude that the digit engine divides down.
// ----------------------------------------------------------------------------
module itrt_front (
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire itrt_pkg::in_word_t s_word,
    output logic                  push_valid,
    input  wire logic             push_ready,
    output itrt_pkg::job_t        push_job
);
    import itrt_pkg::*;

    logic [RADIX_BITS-1:0] base;
    logic [VALUE_BITS-1:0] raw;
    logic                  neg;

    always_comb begin
        if (s_word.radix < RADIX_MIN) begin
            base = RADIX_MIN;
        end else if (s_word.radix > RADIX_MAX) begin
            base = RADIX_MAX;
        end else begin
            base = s_word.radix;
        end
    end

    // Only base ten treats the word as signed; elsewhere the raw pattern is used.
    assign raw = s_word.value;
    assign neg = (base == RADIX_DECIMAL) && raw[VALUE_BITS-1];

    assign push_job.mag  = neg ? (~raw + VALUE_BITS'(1)) : raw;
    assign push_job.base = base;
    assign push_job.neg  = neg;

    assign push_valid = s_valid;
    assign s_ready    = push_ready;

endmodule
`default_nettype wire

>>> rtl/core/itrt_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// itrt_fifo: job queue
// A short queue between the classifier and the digit engine so that either
// side can stall without holding up the other.
// ----------------------------------------------------------------------------
module itrt_fifo (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          push_valid,
    output logic               push_ready,
    input  wire itrt_pkg::job_t push_job,
    output logic               pop_valid,
    input  wire logic          pop_ready,
    output itrt_pkg::job_t     pop_job
);
    import itrt_pkg::*;

    job_t                     mem_reg [FIFO_DEPTH];
    logic [FIFO_PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FIFO_PTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FIFO_CNT_BITS-1:0] count_reg, count_next;
    logic                     push, pop;

    assign push_ready = (count_reg != FIFO_CNT_BITS'(FIFO_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_job    = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == FIFO_PTR_BITS'(FIFO_DEPTH - 1)) ? '0
                        : wr_ptr_reg + FIFO_PTR_BITS'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == FIFO_PTR_BITS'(FIFO_DEPTH - 1)) ? '0
                        : rd_ptr_reg + FIFO_PTR_BITS'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + FIFO_CNT_BITS'(1);
        end else if (pop && !push) begin
            count_next = count_reg - FIFO_CNT_BITS'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= FIFO_CNT_BITS'(FIFO_DEPTH))
        else $error("job queue holds more words than it has entries");

    a_push_only_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !pop) |=> (count_reg == $past(count_reg) + FIFO_CNT_BITS'(1)))
        else $error("job queue lost a pushed word");

    a_pop_only_shrinks: assert property (@(posedge aclk) disable iff (!aresetn)
        (pop && !push) |=> (count_reg == $past(count_reg) - FIFO_CNT_BITS'(1)))
        else $error("job queue kept a popped word");
`endif

endmodule
`default_nettype wire

>>> rtl/core/itrt_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// itrt_back: digit engine
// Divides the magnitude down by the base with a bit-serial restoring divider,
// stores the remainders, then plays them out most significant first, after a minus sign when one is due.
// ----------------------------------------------------------------------------
module itrt_back (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          pop_valid,
    output logic               pop_ready,
    input  wire itrt_pkg::job_t pop_job,
    output logic               m_valid,
    input  wire logic          m_ready,
    output itrt_pkg::out_word_t m_word
);
    import itrt_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_DIV  = 3'b010,
        ST_EMIT = 3'b100
    } back_state_t;

    back_state_t           state_reg, state_next;
    logic [VALUE_BITS-1:0] quot_reg, quot_next;
    logic [REM_BITS-1:0]   rem_reg, rem_next;
    logic [RADIX_BITS-1:0] base_reg, base_next;
    logic                  sign_pending_reg, sign_pending_next;
    logic [IDX_BITS-1:0]   bit_cnt_reg, bit_cnt_next;
    logic [IDX_BITS-1:0]   wr_idx_reg, wr_idx_next;
    logic [IDX_BITS-1:0]   rd_idx_reg, rd_idx_next;
    logic                  m_valid_reg, m_valid_next;
    out_word_t             m_word_reg, m_word_next;
    logic [REM_BITS-1:0]   digit_buf_reg [VALUE_BITS];

    logic [REM_BITS:0]     trial;
    logic                  ge;
    logic [REM_BITS:0]     diff;
    logic [REM_BITS-1:0]   rem_step;
    logic [VALUE_BITS-1:0] quot_step;
    logic                  digit_we;
    logic                  out_free;

    // One quotient bit per cycle.
    assign trial     = {rem_reg, quot_reg[VALUE_BITS-1]};
    assign ge        = trial >= {1'b0, base_reg};
    assign diff      = trial - {1'b0, base_reg};
    assign rem_step  = ge ? diff[REM_BITS-1:0] : trial[REM_BITS-1:0];
    assign quot_step = {quot_reg[VALUE_BITS-2:0], ge};
    assign out_free  = !m_valid_reg || m_ready;

    always_comb begin
        state_next        = state_reg;
        quot_next         = quot_reg;
        rem_next          = rem_reg;
        base_next         = base_reg;
        sign_pending_next = sign_pending_reg;
        bit_cnt_next      = bit_cnt_reg;
        wr_idx_next       = wr_idx_reg;
        rd_idx_next       = rd_idx_reg;
        m_valid_next      = m_valid_reg && !m_ready;
        m_word_next       = m_word_reg;
        pop_ready         = 1'b0;
        digit_we          = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                pop_ready = 1'b1;
                if (pop_valid) begin
                    quot_next         = pop_job.mag;
                    base_next         = pop_job.base;
                    sign_pending_next = pop_job.neg;
                    rem_next          = '0;
                    bit_cnt_next      = IDX_BITS'(VALUE_BITS - 1);
                    wr_idx_next       = '0;
                    state_next        = ST_DIV;
                end
            end
            ST_DIV: begin
                quot_next = quot_step;
                rem_next  = rem_step;
                if (bit_cnt_reg == '0) begin
                    // A zero magnitude still yields one digit, the character zero.
                    digit_we = 1'b1;
                    if (quot_step == '0) begin
                        rd_idx_next = wr_idx_reg;
                        state_next  = ST_EMIT;
                    end else begin
                        wr_idx_next  = wr_idx_reg + IDX_BITS'(1);
                        rem_next     = '0;
                        bit_cnt_next = IDX_BITS'(VALUE_BITS - 1);
                    end
                end else begin
                    bit_cnt_next = bit_cnt_reg - IDX_BITS'(1);
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    if (sign_pending_reg) begin
                        m_word_next.character = CHAR_MINUS;
                        m_word_next.last      = 1'b0;
                        sign_pending_next     = 1'b0;
                    end else begin
                        m_word_next.character = digit_char(digit_buf_reg[rd_idx_reg]);
                        m_word_next.last      = (rd_idx_reg == '0);
                        if (rd_idx_reg == '0) begin
                            state_next = ST_IDLE;
                        end else begin
                            rd_idx_next = rd_idx_reg - IDX_BITS'(1);
                        end
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            sign_pending_reg <= 1'b0;
            m_valid_reg      <= 1'b0;
        end else begin
            state_reg        <= state_next;
            sign_pending_reg <= sign_pending_next;
            m_valid_reg      <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        quot_reg    <= quot_next;
        rem_reg     <= rem_next;
        base_reg    <= base_next;
        bit_cnt_reg <= bit_cnt_next;
        wr_idx_reg  <= wr_idx_next;
        rd_idx_reg  <= rd_idx_next;
        m_word_reg  <= m_word_next;
        if (digit_we) begin
            digit_buf_reg[wr_idx_reg] <= rem_step;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_word  = m_word_reg;

`ifndef SYNTHESIS
    a_base_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV) |-> (base_reg >= RADIX_MIN && base_reg <= RADIX_MAX))
        else $error("divider running with a base out of range");

    a_rem_below_base: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV) |-> ({1'b0, rem_reg} < {1'b0, base_reg}))
        else $error("partial remainder not below the base");

    a_no_sign_when_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> !sign_pending_reg)
        else $error("minus sign left over after a run ended");
`endif

endmodule
`default_nettype wire

>>> rtl/core/integer_to_radix_text.sv
`default_nettype none
// An accepted word is registered in the job queue before the digit engine takes
// it, and each digit is then worked out in the bit-serial divider.
// A word takes longer the more digits it has, plus one more character for a
// minus sign, and longer still while m_ready is low.
// The divider sets the rate; a two-entry queue lets new words in.
// Reset: synchronous, active low; clears the queue, the engine and m_valid.
// ----------------------------------------------------------------------------
// integer_to_radix_text: integer to ASCII text in base 2 to 36
// Each word yields its digits one character per result word, most significant
// first, with a leading minus for negative values in base ten.
// ----------------------------------------------------------------------------
module integer_to_radix_text (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire itrt_pkg::in_word_t s_word,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output itrt_pkg::out_word_t     m_word
);
    import itrt_pkg::*;

    logic push_valid, push_ready;
    job_t push_job;
    logic pop_valid, pop_ready;
    job_t pop_job;

    itrt_front u_front (
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_word     (s_word),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_job   (push_job)
    );

    itrt_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_job   (push_job),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_job    (pop_job)
    );

    itrt_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_job   (pop_job),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_word    (m_word)
    );

endmodule
`default_nettype wire

>>> verif/itrt_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itrt_checker: result checker for the radix text converter
// Watches both channels. Each accepted input word is turned into the text the
// converter should emit, and every result word is compared against it in order.
// ----------------------------------------------------------------------------
module itrt_checker
    import itrt_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_valid,
    input  wire logic      s_ready,
    input  wire in_word_t  s_word,
    input  wire logic      m_valid,
    input  wire logic      m_ready,
    input  wire out_word_t m_word,
    output int             fail_count,
    output int             chars_pending
);

    out_word_t expected_chars[$];
    out_word_t want_word;
    int        mismatches = 0;

    initial begin
        fail_count    = 0;
        chars_pending = 0;
    end

    // Appends the characters of one converted value to the expected stream.
    task automatic queue_text(input in_word_t w);
        logic [RADIX_BITS-1:0] radix;
        logic [VALUE_BITS-1:0] base;
        logic [VALUE_BITS-1:0] mag;
        logic [VALUE_BITS-1:0] rem;
        logic [CHAR_BITS-1:0]  digits[$];
        logic                  neg;
        out_word_t             ow;
        radix = w.radix;
        if (radix < RADIX_MIN) begin
            radix = RADIX_MIN;
        end else if (radix > RADIX_MAX) begin
            radix = RADIX_MAX;
        end
        base = VALUE_BITS'(radix);
        mag  = w.value;
        // Only base ten is signed; elsewhere the raw bit pattern is converted.
        neg  = (radix == RADIX_DECIMAL) && mag[VALUE_BITS-1];
        if (neg) begin
            mag = ~mag + 1'b1;
        end
        do begin
            rem = mag % base;
            if (rem > VALUE_BITS'(DIGIT_NINE)) begin
                digits.push_front(CHAR_LETTER + CHAR_BITS'(rem) - CHAR_TEN);
            end else begin
                digits.push_front(CHAR_ZERO + CHAR_BITS'(rem));
            end
            mag = mag / base;
        end while (mag != 0);
        if (neg) begin
            ow.character = CHAR_MINUS;
            ow.last      = 1'b0;
            expected_chars.push_back(ow);
        end
        foreach (digits[i]) begin
            ow.character = digits[i];
            ow.last      = (i == digits.size() - 1);
            expected_chars.push_back(ow);
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn) begin
            // Results are taken before new inputs; a word cannot answer itself
            // in the cycle it is accepted.
            if (m_valid && m_ready) begin
                if (expected_chars.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("%0t: unexpected word char=%h last=%b", $time,
                                 m_word.character, m_word.last);
                    end
                end else begin
                    want_word = expected_chars.pop_front();
                    if (m_word.character !== want_word.character ||
                        m_word.last !== want_word.last) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("%0t: char exp %h got %h, last exp %b got %b",
                                     $time, want_word.character, m_word.character,
                                     want_word.last, m_word.last);
                        end
                    end
                end
            end
            if (s_valid && s_ready) begin
                queue_text(s_word);
            end
        end
        fail_count    <= mismatches;
        chars_pending <= expected_chars.size();
    end

endmodule

>>> verif/tb_integer_to_radix_text.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_integer_to_radix_text: testbench for the radix text converter
// Directed corner values and bases, then random words sent in bursts while the
// result side stalls on its own pattern; the checker reports any mismatch.
// ----------------------------------------------------------------------------
module tb_integer_to_radix_text;
    import itrt_pkg::*;

    localparam int CYCLE_LIMIT   = 2_000_000;
    localparam int SETTLE_CYCLES = 64;
    localparam int RANDOM_WORDS  = 86;

    typedef enum int {RX_FREE, RX_RANDOM, RX_SPARSE} rx_mode_e;

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_word_t  s_word  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_word_t m_word;

    int       fail_count;
    int       chars_pending;
    int       cycles     = 0;
    int       burst_left = 0;
    rx_mode_e rx_mode    = RX_FREE;
    int       rx_left    = 0;

    always #5 aclk = ~aclk;

    integer_to_radix_text u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_word  (s_word),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_word  (m_word)
    );

    itrt_checker u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_word        (s_word),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_word        (m_word),
        .fail_count    (fail_count),
        .chars_pending (chars_pending)
    );

    // The receiver switches between free running, random and sparse acceptance.
    always @(posedge aclk) begin
        if (rx_left == 0) begin
            rx_mode <= rx_mode_e'($urandom_range(0, 2));
            rx_left <= $urandom_range(20, 300);
        end else begin
            rx_left <= rx_left - 1;
        end
        case (rx_mode)
            RX_FREE:   m_ready <= 1'b1;
            RX_RANDOM: m_ready <= 1'($urandom_range(0, 1));
            default:   m_ready <= ($urandom_range(0, 5) == 0);
        endcase
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb_integer_to_radix_text NOT OK");
            $finish;
        end
    end

    // Sends one word, opening a new burst after a random gap when needed.
    task automatic offer(input logic signed [VALUE_BITS-1:0] v,
                         input logic [RADIX_BITS-1:0] r);
        in_word_t w;
        int       gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 120)
                                              : $urandom_range(0, 6);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 8);
        end
        burst_left--;
        w.value = v;
        w.radix = r;
        s_word  <= w;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        burst_left = 0;
        @(posedge aclk);
        while (chars_pending != 0) @(posedge aclk);
    endtask

    initial begin
        int                           corners[4];
        int                           sel;
        logic signed [VALUE_BITS-1:0] v;
        logic [RADIX_BITS-1:0]        r;
        corners = '{32'sh8000_0000, 32'sh7fff_ffff, 0, -1};

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // Zero in several bases, the extremes and the clamped bases.
        offer(0, 10);
        offer(0, 2);
        offer(0, 36);
        offer(32'sh8000_0000, 10);
        offer(32'sh8000_0000, 16);
        offer(-1, 10);
        offer(-1, 2);
        offer(-1, 36);
        offer(32'sh7fff_ffff, 10);
        offer(32'sh7fff_ffff, 2);
        offer(1, 2);
        offer(35, 36);
        offer(36, 36);
        offer(9, 10);
        offer(10, 11);
        offer(255, 16);
        offer(123456789, 10);
        offer(-42, 10);
        offer(-42, 16);
        offer(5, 0);
        offer(5, 1);
        offer(1000, 37);
        offer(-7, 63);
        offer(32'sh5555_aaaa, 8);
        wait_drained();

        for (int i = 0; i < RANDOM_WORDS; i++) begin
            sel = $urandom_range(0, 9);
            if (sel < 4) begin
                v = $urandom;
            end else if (sel < 6) begin
                v = $urandom_range(0, 200) - 100;
            end else if (sel == 6) begin
                v = corners[$urandom_range(0, 3)] + $urandom_range(0, 4) - 2;
            end else begin
                v = $urandom >> $urandom_range(0, 31);
                if ($urandom_range(0, 1)) begin
                    v = -v;
                end
            end
            sel = $urandom_range(0, 9);
            if (sel < 2) begin
                r = RADIX_DECIMAL;
            end else if (sel == 2) begin
                r = RADIX_BITS'($urandom_range(0, 63));
            end else begin
                r = RADIX_BITS'($urandom_range(2, 36));
            end
            offer(v, r);
            if (i == RANDOM_WORDS / 2) begin
                wait_drained();
            end
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (fail_count == 0 && chars_pending == 0) begin
            $display("tb_integer_to_radix_text OK");
        end else begin
            $display("tb_integer_to_radix_text NOT OK");
        end
        $finish;
    end

endmodule

>>> filelist.f
rtl/core/itrt_pkg.sv
rtl/core/itrt_front.sv
rtl/core/itrt_fifo.sv
rtl/core/itrt_back.sv
rtl/core/integer_to_radix_text.sv
verif/itrt_checker.sv
verif/tb_integer_to_radix_text.sv
